@@ rtl/core/arm_forward_kinematics_3d_top_macros.svh @@
// assertion macros for the arm forward kinematics block
`ifndef ARM_FORWARD_KINEMATICS_3D_TOP_MACROS_SVH
`define ARM_FORWARD_KINEMATICS_3D_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define AFK3_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("assertion failed");
`define AFK3_ASSERT_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (pre) |=> (post)) else $error("assertion failed");
`else
`define AFK3_ASSERT(lbl, prop)
`define AFK3_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/core/afk3_pkg.sv @@
// shared constants, types and the arctangent table of the arm kinematics block
package afk3_pkg;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int TURN_W = 32;
	localparam int CS_W = 33;
	localparam int FIELD_W = 16;
	localparam int OUT_W = 17;
	localparam int IDX_W = 2;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF = 14;
	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sh0FFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 17'sh10000;
	localparam int UPPER_RST = 2000;
	localparam int MIDDLE_RST = 2000;
	localparam int END_RST = 3120;

	typedef enum logic [IDX_W-1:0] {
		REG_UPPER  = 2'd0,
		REG_MIDDLE = 2'd1,
		REG_END    = 2'd2
	} reg_idx_t;

	typedef logic [TURN_W-1:0] turn_t;
	typedef logic signed [CS_W-1:0] cs_t;

	function automatic logic [TURN_W-1:0] atan_turn(input int i);
		logic [TURN_W-1:0] v;
		case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

@@ rtl/core/afk3_cordic.sv @@
// pipelined cordic giving cosine and sine in q30 of a 32-bit turn angle
module afk3_cordic (
	input  logic            clk,
	input  logic            en,
	input  afk3_pkg::turn_t angle,
	output afk3_pkg::cs_t   cos_o,
	output afk3_pkg::cs_t   sin_o
);
	import afk3_pkg::*;

	logic [1:0]            q_in;
	logic [TURN_W-1:0]     res;
	logic [1:0]            q_s [0:CORDIC_STEPS];
	logic signed [CS_W-1:0] x_s [0:CORDIC_STEPS];
	logic signed [CS_W-1:0] y_s [0:CORDIC_STEPS];
	logic signed [CS_W-1:0] z_s [0:CORDIC_STEPS];

	// nearest quadrant split off, residue within a quarter turn
	assign q_in = 2'((angle + 32'h2000_0000) >> 30);
	assign res = angle - {q_in, 30'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0] <= q_in;
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= {res[TURN_W-1], res};
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [CS_W-1:0] ATN = {1'b0, atan_turn(i)};
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][CS_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (q_s[CORDIC_STEPS])
				2'd0: begin
					cos_o <= x_s[CORDIC_STEPS];
					sin_o <= y_s[CORDIC_STEPS];
				end
				2'd1: begin
					cos_o <= -y_s[CORDIC_STEPS];
					sin_o <= x_s[CORDIC_STEPS];
				end
				2'd2: begin
					cos_o <= -x_s[CORDIC_STEPS];
					sin_o <= -y_s[CORDIC_STEPS];
				end
				default: begin
					cos_o <= y_s[CORDIC_STEPS];
					sin_o <= -x_s[CORDIC_STEPS];
				end
			endcase
		end
	end
endmodule

@@ rtl/core/arm_forward_kinematics_3d_top.sv @@
// Forward kinematics of a three-link arm on a turning base: one item per clock,
// one angle stage, 32 stages of the four parallel cordic pipelines, five
// multiply, sum and rounding stages. The whole pipeline holds while a result
// waits on res_stall; users change link lengths only while idle, not enforced.
`include "arm_forward_kinematics_3d_top_macros.svh"
module arm_forward_kinematics_3d_top #(
	parameter int ANGLE_BITS = afk3_pkg::ANGLE_BITS_DEF,
	parameter int LENGTH_BITS = afk3_pkg::LENGTH_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic signed [afk3_pkg::FIELD_W-1:0]    yaw_angle,
	input  logic signed [afk3_pkg::FIELD_W-1:0]    shoulder_angle,
	input  logic signed [afk3_pkg::FIELD_W-1:0]    elbow_angle,
	input  logic signed [afk3_pkg::FIELD_W-1:0]    wrist_angle,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic signed [afk3_pkg::OUT_W-1:0]      pos_x,
	output logic signed [afk3_pkg::OUT_W-1:0]      pos_y,
	output logic signed [afk3_pkg::OUT_W-1:0]      pos_z,
	input  logic                                   cfg_we,
	input  logic [afk3_pkg::IDX_W-1:0]             cfg_index,
	input  logic [LENGTH_BITS-1:0]                 cfg_wdata
);
	import afk3_pkg::*;

	localparam int PW = LENGTH_BITS + CS_W + 1;
	localparam int SW = PW + 2;
	localparam int RW = SW - 22;
	localparam int XW = RW + CS_W;
	localparam logic signed [SW-1:0] HALF_R = SW'(1) << 21;
	localparam logic signed [SW-1:0] HALF_H = SW'(1) << 29;
	localparam logic signed [XW-1:0] HALF_X = XW'(1) << 37;

	logic en;
	logic [LENGTH_BITS-1:0] len_q [0:2];

	logic                    vld_s1;
	turn_t                   ang_s1 [0:3];
	logic [CORDIC_LAT-1:0]   cvld_q;
	cs_t                     c_w [0:3];
	cs_t                     s_w [0:3];

	logic                    vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [PW-1:0]    pc_s2 [0:2];
	logic signed [PW-1:0]    ps_s2 [0:2];
	cs_t                     cb_s2, sb_s2, cb_s3, sb_s3, cb_s4, sb_s4;
	logic signed [SW-1:0]    reach_s3, height_s3;
	logic signed [SW-1:0]    r_rnd, h_rnd;
	logic signed [RW-1:0]    r8_s4;
	logic signed [OUT_W-1:0] z_s4, z_s5;
	logic signed [XW-1:0]    px_s5, py_s5, x_rnd, y_rnd;
	logic                    out_vld_q;

	function automatic logic signed [OUT_W-1:0] sat_w(input logic signed [XW-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > OUT_MAX)
			r = OUT_MAX;
		else if (v < OUT_MIN)
			r = OUT_MIN;
		else
			r = OUT_W'(v);
		return r;
	endfunction

	function automatic turn_t to_turn(input logic signed [FIELD_W-1:0] f);
		logic [TURN_W-1:0] e;
		e = TURN_W'(f);
		return e << (TURN_W - ANGLE_BITS);
	endfunction

	// the whole pipeline moves unless a result is held
	assign en = !out_vld_q || !res_stall;
	assign item_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[0] <= LENGTH_BITS'(UPPER_RST);
			len_q[1] <= LENGTH_BITS'(MIDDLE_RST);
			len_q[2] <= LENGTH_BITS'(END_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UPPER:  len_q[0] <= cfg_wdata;
				REG_MIDDLE: len_q[1] <= cfg_wdata;
				REG_END:    len_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cvld_q <= '0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			cvld_q <= {cvld_q[CORDIC_LAT-2:0], vld_s1};
			vld_s2 <= cvld_q[CORDIC_LAT-1];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			out_vld_q <= vld_s5;
		end
	end

	// cumulative joint angles wrap modulo a turn
	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1[0] <= to_turn(yaw_angle);
			ang_s1[1] <= to_turn(shoulder_angle);
			ang_s1[2] <= to_turn(shoulder_angle) + to_turn(elbow_angle);
			ang_s1[3] <= to_turn(shoulder_angle) + to_turn(elbow_angle)
				+ to_turn(wrist_angle);
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_cordic
		afk3_cordic u_cordic (
			.clk   (clk),
			.en    (en),
			.angle (ang_s1[k]),
			.cos_o (c_w[k]),
			.sin_o (s_w[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pc_s2[j] <= PW'(signed'({1'b0, len_q[j]}) * c_w[j+1]);
				ps_s2[j] <= PW'(signed'({1'b0, len_q[j]}) * s_w[j+1]);
			end
			cb_s2 <= c_w[0];
			sb_s2 <= s_w[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			reach_s3 <= SW'(pc_s2[0]) + SW'(pc_s2[1]) + SW'(pc_s2[2]);
			height_s3 <= SW'(ps_s2[0]) + SW'(ps_s2[1]) + SW'(ps_s2[2]);
			cb_s3 <= cb_s2;
			sb_s3 <= sb_s2;
		end
	end

	assign r_rnd = (reach_s3 + HALF_R) >>> 22;
	assign h_rnd = (height_s3 + HALF_H) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			r8_s4 <= RW'(r_rnd);
			z_s4 <= sat_w(XW'(h_rnd));
			cb_s4 <= cb_s3;
			sb_s4 <= sb_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5 <= XW'(r8_s4 * cb_s4);
			py_s5 <= XW'(r8_s4 * sb_s4);
			z_s5 <= z_s4;
		end
	end

	assign x_rnd = (px_s5 + HALF_X) >>> 38;
	assign y_rnd = (py_s5 + HALF_X) >>> 38;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_x <= sat_w(x_rnd);
			pos_y <= sat_w(y_rnd);
			pos_z <= z_s5;
		end
	end

	assign res_valid = out_vld_q;

	`AFK3_ASSERT(a_rise_from_pipe, $rose(out_vld_q) |-> $past(vld_s5))
	`AFK3_ASSERT_NEXT(a_empty_stays, !out_vld_q && !vld_s5, !out_vld_q)
	`AFK3_ASSERT_NEXT(a_hold_pipe, out_vld_q && res_stall, $stable(cvld_q))
endmodule

@@ tb/tb_top.sv @@
// testbench for the three-link arm forward kinematics block: predicted positions vs results
`timescale 1ns / 1ps

class arm_pose_scoreboard;
	typedef struct {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic signed [16:0] z;
	} pose_t;

	localparam longint ATAN_TURN [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304,
		652, 326, 163, 81, 41,
		20, 10, 5, 3, 1
	};

	pose_t pending[$];
	longint link_len [3];
	int mismatches;
	int poses_checked;

	function new();
		link_len[0] = afk3_pkg::UPPER_RST;
		link_len[1] = afk3_pkg::MIDDLE_RST;
		link_len[2] = afk3_pkg::END_RST;
		mismatches = 0;
		poses_checked = 0;
	endfunction

	function void set_length(logic [1:0] idx, logic [13:0] v);
		if (idx <= afk3_pkg::REG_END)
			link_len[idx] = v;
	endfunction

	// q30 cosine and sine of a 32-bit turn angle
	function void cos_sin(input logic [31:0] a, output longint c, output longint s);
		logic [1:0] quad;
		logic [31:0] resid;
		longint x, y, z, dx, dy;
		quad = 2'((a + 32'h2000_0000) >> 30);
		resid = a - {quad, 30'b0};
		z = longint'($signed(resid));
		x = longint'(afk3_pkg::CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TURN[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TURN[i];
			end
		end
		case (quad)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function longint round_down(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function logic signed [16:0] clamp17(longint v);
		if (v > 65535) return 17'sh0FFFF;
		if (v < -65536) return 17'sh10000;
		return 17'(v);
	endfunction

	function void note_item(logic [15:0] b, logic [15:0] s, logic [15:0] e, logic [15:0] w);
		logic [31:0] tb, t1, t2, t3;
		longint c, sn, reach, height, r8, cb, sb;
		pose_t p;
		tb = {b, 16'b0};
		t1 = {s, 16'b0};
		t2 = t1 + {e, 16'b0};
		t3 = t2 + {w, 16'b0};
		cos_sin(t1, c, sn);
		reach = link_len[0] * c;
		height = link_len[0] * sn;
		cos_sin(t2, c, sn);
		reach += link_len[1] * c;
		height += link_len[1] * sn;
		cos_sin(t3, c, sn);
		reach += link_len[2] * c;
		height += link_len[2] * sn;
		r8 = round_down(reach, 22);
		cos_sin(tb, cb, sb);
		p.x = clamp17(round_down(r8 * cb, 38));
		p.y = clamp17(round_down(r8 * sb, 38));
		p.z = clamp17(round_down(height, 30));
		pending.push_back(p);
	endfunction

	function void check_pose(logic signed [16:0] x, logic signed [16:0] y,
		logic signed [16:0] z);
		pose_t p;
		poses_checked++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result x=%0d y=%0d z=%0d", x, y, z);
			return;
		end
		p = pending.pop_front();
		if (p.x !== x || p.y !== y || p.z !== z) begin
			mismatches++;
			if (mismatches <= 10)
				$display("pose mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
					p.x, p.y, p.z, x, y, z);
		end
	endfunction
endclass

module tb_top;
	import afk3_pkg::*;

	localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
	localparam int STALL_LIMIT = 5000;

	logic clk, arst_n;
	logic item_valid, item_stall, res_valid, res_stall;
	logic signed [15:0] yaw_angle, shoulder_angle, elbow_angle, wrist_angle;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [13:0] cfg_wdata;
	logic calm;
	int idle_cycles;
	arm_pose_scoreboard poses;

	arm_forward_kinematics_3d_top DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.yaw_angle(yaw_angle), .shoulder_angle(shoulder_angle),
		.elbow_angle(elbow_angle), .wrist_angle(wrist_angle),
		.res_valid(res_valid), .res_stall(res_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk)
		res_stall <= !calm && ($urandom_range(0, 99) < 9);

	always @(posedge clk)
		if (arst_n && res_valid && !res_stall)
			poses.check_pose(pos_x, pos_y, pos_z);

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_item(logic [15:0] b, logic [15:0] s, logic [15:0] e, logic [15:0] w);
		while (!calm && $urandom_range(0, 99) < 9) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		yaw_angle <= b;
		shoulder_angle <= s;
		elbow_angle <= e;
		wrist_angle <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		poses.note_item(b, s, e, w);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (poses.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_length(logic [IDX_W-1:0] idx, logic [13:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		poses.set_length(idx, v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(int n);
		repeat (n)
			send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		logic [15:0] corner [13];
		corner = '{16'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd1, 16'd8192, 16'hE000,
			16'd16384, 16'hC000, 16'd24576, 16'hA000, 16'd8191, 16'd12345};
		poses = new();
		calm = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		yaw_angle = '0;
		shoulder_angle = '0;
		elbow_angle = '0;
		wrist_angle = '0;
		cfg_we = 1'b0;
		cfg_index = REG_UPPER;
		cfg_wdata = '0;
		res_stall = 1'b0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// corner angles at reset lengths
		for (int i = 0; i < 13; i++)
			send_item(corner[i], corner[(i + 3) % 13], corner[(i + 7) % 13],
				corner[(i + 11) % 13]);
		drain();

		// longest links, arm straight out and folded
		write_length(REG_UPPER, 14'h3FFF);
		write_length(REG_MIDDLE, 14'h3FFF);
		write_length(REG_END, 14'h3FFF);
		write_length(REG_NONE, 14'h0123);
		send_item(16'd0, 16'd0, 16'd0, 16'd0);
		send_item(16'h8000, 16'h7FFF, 16'd0, 16'd0);
		send_item(16'd8192, 16'hC000, 16'd0, 16'd0);
		send_item(16'hFFFF, 16'd16384, 16'h8000, 16'h8000);
		drain();

		// zero-length links
		write_length(REG_UPPER, 14'd0);
		write_length(REG_MIDDLE, 14'd0);
		write_length(REG_END, 14'd0);
		send_item(16'd1234, 16'h8000, 16'h7FFF, 16'd1);
		random_items(4);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_length(REG_UPPER, 14'($urandom));
			write_length(REG_MIDDLE, 14'($urandom));
			write_length(REG_END, 14'($urandom));
			if (ph == 2)
				write_length(REG_NONE, 14'($urandom));
			calm = (ph == 3);
			random_items(200);
			drain();
		end
		calm = 1'b0;

		repeat (50) @(posedge clk);
		$display("checked %0d poses over corner angles, extreme and random link lengths",
			poses.poses_checked);
		$display("%0d mismatches", poses.mismatches);
		if (poses.mismatches == 0 && poses.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
